[rtl/fratr_pkg.sv]
// ----------------------------------------------------------------------------
// fratr_pkg
// Shared types and constants of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package fratr_pkg;

    // default geometry
    localparam int BUCKETS_DEF  = 256;
    localparam int WAYS_DEF     = 2;
    localparam int MAP_BITS_DEF = 64;

    // configuration reset values
    localparam logic [5:0]  HDR_LEN_RESET   = 6'd16;
    localparam logic [15:0] FRAG_SIZE_RESET = 16'd240;

    // header field masks
    localparam logic [3:0] SEQ_LOW_MASK = 4'hF;

    // tag entry: valid, 24-bit source, 12-bit sequence
    localparam int TAG_W   = 37;
    localparam int TAG_VLD = 36;

    // count entry: arrived count over needed count
    localparam int NEED_W = 17;
    localparam int ARR_W  = 14;
    localparam int CNT_W  = NEED_W + ARR_W;

    // divider geometry
    localparam int DIVN_W = 17;
    localparam int DIVD_W = 16;
    localparam logic [4:0] DIV_STEPS = 5'd17;

    // configuration register indexes
    localparam logic CFG_HDR_LEN   = 1'b0;
    localparam logic CFG_FRAG_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_RAW         = 3'd0,
        ST_RAW_SHORT   = 3'd1,
        ST_FRAME_SHORT = 3'd2,
        ST_STORED      = 3'd3,
        ST_COMPLETE    = 3'd4,
        ST_BAD_OFFSET  = 3'd5,
        ST_DUPLICATE   = 3'd6,
        ST_FULL        = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_TAG,
        S_MATCH,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [8:0]  slot_index;
        logic [5:0]  fragment_index;
        logic [15:0] write_offset;
        logic [15:0] copy_length;
        logic [16:0] message_length;
        logic        copy_header;
    } t_result;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

[rtl/fragment_reassembly_tracker_unit.sv]
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_unit
// Tracks fragments of received messages in a hashed, set-associative slot
// table and reports where each fragment's payload belongs.
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      frame header fields
// out       output     o_out_valid / i_out_ready    status and copy info
// cfg       input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// short, dropped and raw frames get their result in S_PRE, then pass out via S_FIN
// a bucket-full frame goes through S_PRE, S_TAG and S_MATCH; a tracked fragment also waits
// in S_DIV for the 17-step dividers for fragment index and needed count
// the next transaction is taken in the cycle after the output register loads
// after reset the tag table is cleared by a sweep over all buckets, no input taken
// one output register: a new transaction is taken while a result waits
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit #(
    parameter int BUCKETS  = fratr_pkg::BUCKETS_DEF,
    parameter int WAYS     = fratr_pkg::WAYS_DEF,
    parameter int MAP_BITS = fratr_pkg::MAP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_frame_length,
    input  logic [23:0] i_source_address,
    input  logic [15:0] i_offset_word,
    input  logic [7:0]  i_sequence_byte,
    input  logic [15:0] i_length_word,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [8:0]  o_slot_index,
    output logic [5:0]  o_fragment_index,
    output logic [15:0] o_write_offset,
    output logic [15:0] o_copy_length,
    output logic [16:0] o_message_length,
    output logic        o_copy_header
);

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int BW    = $clog2(BUCKETS);
    localparam int SW    = $clog2(SLOTS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MW    = $clog2(MAP_BITS);
    localparam int ROW_W = WAYS * fratr_pkg::TAG_W;
    localparam int TW    = fratr_pkg::TAG_W;
    localparam int NW    = fratr_pkg::NEED_W;
    localparam int AW    = fratr_pkg::ARR_W;

    fratr_pkg::t_state  r_state, n_state;

    // configuration registers
    logic [5:0]  r_hdr_len;
    logic [15:0] r_frag_size;

    // captured transaction
    logic [15:0] r_flen;
    logic [23:0] r_src;
    logic [15:0] r_offw;
    logic [7:0]  r_seq8;
    logic [15:0] r_lenw;

    logic [SW-1:0] r_slot;
    logic [WW-1:0] r_way;
    logic          r_alloc;

    fratr_pkg::t_result r_res, n_res;
    fratr_pkg::t_result r_out;
    logic               r_ovalid;

    // control groups
    fratr_pkg::t_mem_ctl tag_ctl, store_ctl;
    logic                div_start, div_done, res_load, out_load, in_acc;
    logic                clearing;

    // derived header values
    logic [16:0]  msg_len;
    logic [15:0]  fsize;
    logic [16:0]  off17;
    logic [11:0]  seq12;
    logic [15:0]  blen;
    logic         frame_short, is_raw;
    logic [23:0]  hash;
    logic [BW-1:0] bucket;
    logic [TW-1:0] new_tag;

    // memory data
    logic [ROW_W-1:0]           tag_row, tag_wrow;
    logic [fratr_pkg::CNT_W-1:0] rcnt, wcnt;
    logic [MAP_BITS-1:0]        rmap, wmap, eff_map, set_map;

    // lookup
    logic          hit, free;
    logic [WW-1:0] hit_way, free_way, sel_way;
    logic [SW-1:0] sel_slot;

    // divider results
    logic          busy_ind, busy_need;
    logic [16:0]   ind_q, need_q;
    logic [15:0]   ind_r, need_r;

    // update
    logic [NW-1:0] need_new, need_eff;
    logic [AW-1:0] arr_eff, arr_new;
    logic          bad, dup, upd, complete;
    logic [16:0]   end_pos;
    logic [15:0]   clen;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len   <= fratr_pkg::HDR_LEN_RESET;
            r_frag_size <= fratr_pkg::FRAG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fratr_pkg::CFG_HDR_LEN:   r_hdr_len   <= i_cfg_data[5:0];
                fratr_pkg::CFG_FRAG_SIZE: r_frag_size <= i_cfg_data;
                default:                  r_hdr_len   <= r_hdr_len;
            endcase
        end
    end

    // header decode
    always_comb begin
        msg_len     = {1'b0, r_lenw} + 17'd1;
        fsize       = (r_frag_size == 16'd0) ? 16'd1 : r_frag_size;
        off17       = {1'b0, r_offw & ~{12'd0, fratr_pkg::SEQ_LOW_MASK}};
        seq12       = {r_offw[3:0] & fratr_pkg::SEQ_LOW_MASK, r_seq8};
        frame_short = (r_flen < {10'd0, r_hdr_len});
        blen        = r_flen - {10'd0, r_hdr_len};
        is_raw      = (msg_len <= {1'b0, fsize});
        hash        = (r_src >> 16) ^ r_src ^ {12'd0, seq12};
        bucket      = BW'(hash & 24'(BUCKETS - 1));
        new_tag     = {1'b1, r_src, seq12};
    end

    // way lookup over the bucket row
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (tag_row[w*TW +: TW] == new_tag) begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
            if (!tag_row[w*TW + fratr_pkg::TAG_VLD]) begin
                free     = 1'b1;
                free_way = WW'(w);
            end
        end
        sel_way  = hit ? hit_way : free_way;
        sel_slot = SW'(bucket) * SW'(WAYS) + SW'(sel_way);
    end

    // fragment update
    always_comb begin
        need_new = NW'(need_q) + NW'(need_r != 16'd0);
        need_eff = r_alloc ? need_new : rcnt[NW-1:0];
        arr_eff  = r_alloc ? '0 : rcnt[fratr_pkg::CNT_W-1:NW];
        eff_map  = r_alloc ? '0 : rmap;
        arr_new  = arr_eff + AW'(1);
        bad      = (off17 >= msg_len) || (ind_q >= 17'(MAP_BITS));
        dup      = !bad && eff_map[ind_q[MW-1:0]];
        upd      = !bad && !dup;
        complete = upd && ({{(NW-AW){1'b0}}, arr_new} == need_eff);
        set_map  = eff_map | (MAP_BITS'(1) << ind_q[MW-1:0]);
        wcnt     = upd ? {arr_new, need_eff} : {arr_eff, need_eff};
        wmap     = upd ? set_map : eff_map;
        end_pos  = off17 + {1'b0, blen};
        clen     = (end_pos > msg_len) ? 16'(msg_len - off17) : blen;
        tag_wrow = tag_row;
        for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == r_way) begin
                tag_wrow[w*TW +: TW] = complete ? '0 : new_tag;
            end
        end
    end

    // result selection
    always_comb begin
        n_res                = '0;
        n_res.message_length = msg_len;
        priority if (r_state == fratr_pkg::S_PRE) begin
            if (frame_short) begin
                n_res.status = fratr_pkg::ST_FRAME_SHORT;
            end else if (blen < msg_len[15:0] || msg_len[16]) begin
                n_res.status = fratr_pkg::ST_RAW_SHORT;
            end else begin
                n_res.status      = fratr_pkg::ST_RAW;
                n_res.copy_length = msg_len[15:0];
                n_res.copy_header = 1'b1;
            end
        end else if (r_state == fratr_pkg::S_MATCH) begin
            n_res.status = fratr_pkg::ST_FULL;
        end else begin
            n_res.slot_index = 9'(r_slot);
            if (bad) begin
                n_res.status = fratr_pkg::ST_BAD_OFFSET;
            end else if (dup) begin
                n_res.status         = fratr_pkg::ST_DUPLICATE;
                n_res.fragment_index = ind_q[5:0];
            end else begin
                n_res.status         = complete ? fratr_pkg::ST_COMPLETE
                                                : fratr_pkg::ST_STORED;
                n_res.fragment_index = ind_q[5:0];
                n_res.write_offset   = off17[15:0];
                n_res.copy_length    = clen;
                n_res.copy_header    = (off17 == 17'd0);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fratr_pkg::S_IDLE:  if (in_acc) n_state = fratr_pkg::S_PRE;
            fratr_pkg::S_PRE:   n_state = (frame_short || is_raw) ? fratr_pkg::S_FIN
                                                                  : fratr_pkg::S_TAG;
            fratr_pkg::S_TAG:   n_state = fratr_pkg::S_MATCH;
            fratr_pkg::S_MATCH: n_state = (hit || free) ? fratr_pkg::S_DIV
                                                        : fratr_pkg::S_FIN;
            fratr_pkg::S_DIV:   if (div_done) n_state = fratr_pkg::S_FIN;
            fratr_pkg::S_FIN:   if (out_load) n_state = fratr_pkg::S_IDLE;
            default:            n_state = fratr_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_acc          = i_in_valid && o_in_ready;
        div_start       = (r_state == fratr_pkg::S_PRE) && !frame_short && !is_raw;
        tag_ctl.rd_en   = div_start;
        div_done        = (r_state == fratr_pkg::S_DIV) && !busy_ind && !busy_need;
        store_ctl.rd_en = (r_state == fratr_pkg::S_MATCH) && (hit || free);
        store_ctl.wr_en = div_done && (r_alloc || upd);
        tag_ctl.wr_en   = div_done && (r_alloc || complete);
        res_load        = ((r_state == fratr_pkg::S_PRE) && (frame_short || is_raw))
                       || ((r_state == fratr_pkg::S_MATCH) && !hit && !free)
                       || div_done;
        out_load        = (r_state == fratr_pkg::S_FIN) && (!r_ovalid || i_out_ready);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fratr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // transaction capture, slot choice, result and output loads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_flen <= i_frame_length;
            r_src  <= i_source_address;
            r_offw <= i_offset_word;
            r_seq8 <= i_sequence_byte;
            r_lenw <= i_length_word;
        end
        if (store_ctl.rd_en) begin
            r_slot  <= sel_slot;
            r_way   <= sel_way;
            r_alloc <= !hit;
        end
        if (res_load) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    fratr_tag_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_tags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tag_ctl),
        .i_addr     (bucket),
        .i_wdata    (tag_wrow),
        .o_rdata    (tag_row),
        .o_clearing (clearing)
    );

    fratr_slot_store #(
        .SLOTS    (SLOTS),
        .MAP_BITS (MAP_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_ctl  (store_ctl),
        .i_addr (store_ctl.rd_en ? sel_slot : r_slot),
        .i_wcnt (wcnt),
        .i_wmap (wmap),
        .o_rcnt (rcnt),
        .o_rmap (rmap)
    );

    // fragment index: offset over fragment size
    fratr_divider u_div_ind (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (off17),
        .i_divisor   (fsize),
        .o_busy      (busy_ind),
        .o_quotient  (ind_q),
        .o_remainder (ind_r)
    );

    // needed count: message length over fragment size, rounded up
    fratr_divider u_div_need (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (msg_len),
        .i_divisor   (fsize),
        .o_busy      (busy_need),
        .o_quotient  (need_q),
        .o_remainder (need_r)
    );

    assign o_in_ready       = (r_state == fratr_pkg::S_IDLE) && !clearing;
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_out.status;
    assign o_slot_index     = r_out.slot_index;
    assign o_fragment_index = r_out.fragment_index;
    assign o_write_offset   = r_out.write_offset;
    assign o_copy_length    = r_out.copy_length;
    assign o_message_length = r_out.message_length;
    assign o_copy_header    = r_out.copy_header ^ (ind_r[0] & 1'b0);

`ifndef SYNTHESIS
    // no tag write while the clearing sweep owns the memory
    a_no_write_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !tag_ctl.wr_en)
        else $error("tag write during clearing sweep");

    // both dividers start together and run the same number of steps
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy_ind == busy_need))
        else $error("dividers out of step");

    // stored fragments start inside the message
    a_offset_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_out.status == fratr_pkg::ST_STORED
                   || r_out.status == fratr_pkg::ST_COMPLETE))
        |-> ({1'b0, r_out.write_offset} < r_out.message_length))
        else $error("stored fragment offset beyond message end");
`endif

endmodule

[rtl/fratr_divider.sv]
// ----------------------------------------------------------------------------
// fratr_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fratr_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [fratr_pkg::DIVN_W-1:0]   i_dividend,
    input  logic [fratr_pkg::DIVD_W-1:0]   i_divisor,
    output logic                           o_busy,
    output logic [fratr_pkg::DIVN_W-1:0]   o_quotient,
    output logic [fratr_pkg::DIVD_W-1:0]   o_remainder
);

    logic                          r_busy;
    logic [4:0]                    r_cnt;
    logic [fratr_pkg::DIVN_W-1:0]  r_quo;
    logic [fratr_pkg::DIVD_W-1:0]  r_rem;
    logic [fratr_pkg::DIVD_W-1:0]  r_div;

    logic [fratr_pkg::DIVD_W:0]    trial;
    logic [fratr_pkg::DIVD_W:0]    diff;
    logic                          ge;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_quo[fratr_pkg::DIVN_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= fratr_pkg::DIV_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fratr_pkg::DIVN_W-2:0], ge};
            r_rem <= ge ? diff[fratr_pkg::DIVD_W-1:0] : trial[fratr_pkg::DIVD_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/fratr_tag_table.sv]
// ----------------------------------------------------------------------------
// fratr_tag_table
// Tag memory, one row of all ways per bucket, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module fratr_tag_table #(
    parameter int BUCKETS = fratr_pkg::BUCKETS_DEF,
    parameter int WAYS    = fratr_pkg::WAYS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fratr_pkg::t_mem_ctl                 i_ctl,
    input  logic [$clog2(BUCKETS)-1:0]          i_addr,
    input  logic [WAYS*fratr_pkg::TAG_W-1:0]    i_wdata,
    output logic [WAYS*fratr_pkg::TAG_W-1:0]    o_rdata,
    output logic                                o_clearing
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int ROW_W = WAYS * fratr_pkg::TAG_W;

    logic [ROW_W-1:0] mem [BUCKETS];
    logic [ROW_W-1:0] r_rdata;
    logic             r_clearing;
    logic [BW-1:0]    r_clr_addr;

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + BW'(1);
            if (r_clr_addr == BW'(BUCKETS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr_en) begin
            mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

[rtl/fratr_slot_store.sv]
// ----------------------------------------------------------------------------
// fratr_slot_store
// Per-slot counts and seen bitmaps; a slot must be written at allocation before its read data is used,
// which the store itself does not enforce.
module fratr_slot_store #(
    parameter int SLOTS    = fratr_pkg::BUCKETS_DEF * fratr_pkg::WAYS_DEF,
    parameter int MAP_BITS = fratr_pkg::MAP_BITS_DEF
) (
    input  logic                          i_clk,
    input  fratr_pkg::t_mem_ctl           i_ctl,
    input  logic [$clog2(SLOTS)-1:0]      i_addr,
    input  logic [fratr_pkg::CNT_W-1:0]   i_wcnt,
    input  logic [MAP_BITS-1:0]           i_wmap,
    output logic [fratr_pkg::CNT_W-1:0]   o_rcnt,
    output logic [MAP_BITS-1:0]           o_rmap
);

    logic [fratr_pkg::CNT_W-1:0] cnt_mem [SLOTS];
    logic [MAP_BITS-1:0]         map_mem [SLOTS];
    logic [fratr_pkg::CNT_W-1:0] r_rcnt;
    logic [MAP_BITS-1:0]         r_rmap;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            cnt_mem[i_addr] <= i_wcnt;
            map_mem[i_addr] <= i_wmap;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rcnt <= cnt_mem[i_addr];
            r_rmap <= map_mem[i_addr];
        end
    end

    assign o_rcnt = r_rcnt;
    assign o_rmap = r_rmap;

endmodule
